>>> rtl/ppu_pkg.sv
// Package for the particle pool update unit: types, constants and lane codes.
`timescale 1ns / 1ps
package ppu_pkg;

    localparam int SLOTS_DEF = 64;
    localparam int SLOT_W    = 6;

    typedef struct packed {
        logic        operation;
        logic [15:0] life;
        logic [31:0] position;
        logic [31:0] velocity;
        logic [31:0] accel;
        logic [31:0] size_from;
        logic [31:0] size_to;
        logic [23:0] color_from;
        logic [23:0] color_to;
        logic [15:0] alpha_pair;
    } in_item_t;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [31:0]       position_out;
        logic [31:0]       size_out;
        logic [23:0]       color_out;
        logic [7:0]        alpha_out;
        logic              accepted;
        logic              last;
    } out_item_t;

    // One slot record in the store
    typedef struct packed {
        logic [15:0] frame;
        logic [15:0] life;
        logic [31:0] pos;
        logic [31:0] vel;
        logic [31:0] acc;
        logic [63:0] size;   // from low 32, to high 32
        logic [47:0] color;  // from low 24, to high 24
        logic [15:0] alpha;  // from low 8, to high 8
    } entry_t;

    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE, S_ADD, S_FREE_RD, S_FREE_CHK, S_FIND, S_LOAD,
        S_VEL, S_POS, S_LGO, S_LWAIT, S_WB, S_EMIT
    } pp_state_t;

    typedef enum logic [2:0] {
        LN_SIZE_X, LN_SIZE_Y, LN_RED, LN_GREEN, LN_BLUE, LN_ALPHA
    } pp_lane_t;

    typedef enum logic [1:0] {
        L_IDLE, L_MUL, L_DIV, L_DONE
    } lerp_state_t;

endpackage

>>> rtl/ppu_store.sv
// Slot record memory: one write port, one registered read port.
`timescale 1ns / 1ps
module ppu_store #(
    parameter int SLOTS = ppu_pkg::SLOTS_DEF,
    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic                  clk,
    input  logic                  we,
    input  logic [AW-1:0]         wr_addr,
    input  ppu_pkg::entry_t       wr_data,
    input  logic                  rd_en,
    input  logic [AW-1:0]         rd_addr,
    output ppu_pkg::entry_t       rd_data
);
    ppu_pkg::entry_t mem [SLOTS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule

>>> rtl/ppu_lerp.sv
// Serial interpolator: from + (to - from) * num / den, truncated toward zero.
`timescale 1ns / 1ps
module ppu_lerp (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [15:0] from_val,
    input  logic [15:0] to_val,
    input  logic [15:0] num,
    input  logic [15:0] den,
    output logic        done,
    output logic [15:0] result
);
    ppu_pkg::lerp_state_t state_reg, state_next;
    logic        neg_reg;
    logic [15:0] mag_reg, from_reg, num_reg, den_reg, rem_reg;
    logic [31:0] quo_reg;
    logic [4:0]  cnt_reg;
    logic [16:0] diff;
    logic [16:0] rem_sh;
    logic        fits;

    assign diff   = {1'b0, to_val} - {1'b0, from_val};
    assign rem_sh = {rem_reg, quo_reg[31]};
    assign fits   = (rem_sh >= {1'b0, den_reg});

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ppu_pkg::L_IDLE: if (start) state_next = ppu_pkg::L_MUL;
            ppu_pkg::L_MUL:  state_next = ppu_pkg::L_DIV;
            ppu_pkg::L_DIV:  if (cnt_reg == 5'd31) state_next = ppu_pkg::L_DONE;
            ppu_pkg::L_DONE: state_next = ppu_pkg::L_IDLE;
            default:         state_next = ppu_pkg::L_IDLE;
        endcase
    end

    always_comb
    begin
        done   = (state_reg == ppu_pkg::L_DONE);
        result = neg_reg ? (from_reg - quo_reg[15:0]) : (from_reg + quo_reg[15:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ppu_pkg::L_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ppu_pkg::L_IDLE:
            begin
                if (start)
                begin
                    neg_reg  <= diff[16];
                    mag_reg  <= diff[16] ? 16'(-diff) : diff[15:0];
                    from_reg <= from_val;
                    num_reg  <= num;
                    den_reg  <= den;
                end
            end
            ppu_pkg::L_MUL:
            begin
                quo_reg <= mag_reg * num_reg;
                rem_reg <= '0;
                cnt_reg <= '0;
            end
            ppu_pkg::L_DIV:
            begin
                // one restoring step per cycle
                rem_reg <= fits ? 16'(rem_sh - {1'b0, den_reg}) : rem_sh[15:0];
                quo_reg <= {quo_reg[30:0], fits};
                cnt_reg <= cnt_reg + 5'd1;
            end
            default:
            begin
            end
        endcase
    end
endmodule

>>> rtl/particle_pool_update_unit.sv
// Top level of the particle pool update unit: sequencer, slot flags, output register.
`timescale 1ns / 1ps
// A pool of SLOTS particle slots. An add transfer stores a particle in the lowest free
// slot and returns one result (accepted = 0 when the pool is full), after any wait for
// the output register. A tick transfer first sweeps all slots to free expired ones,
// then walks the slots in ascending order and, for each live one, updates velocity and
// position with saturation and interpolates six lanes (size x/y, red, green, blue,
// alpha). All lanes share one serial interpolator whose 32-step restoring divider sets
// the pace. One result per live slot, last marks the final one; a tick with no live
// slot returns nothing. in_ready is low from acceptance until the sequencer is idle
// again, which for a tick is after the last result is loaded and the remaining slots
// are scanned.
module particle_pool_update_unit #(
    parameter int SLOTS = ppu_pkg::SLOTS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  ppu_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output ppu_pkg::out_item_t out_data
);
    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1) + 1;

    ppu_pkg::pp_state_t state_reg, state_next;
    logic [SLOTS-1:0]   live_reg;
    logic [CW-1:0]      cnt_reg;
    ppu_pkg::in_item_t  in_reg;
    ppu_pkg::entry_t    ent_reg;
    logic [15:0]        fr_reg;
    logic [31:0]        vel_reg, pos_reg, size_res_reg;
    logic [23:0]        color_res_reg;
    logic [7:0]         alpha_res_reg;
    ppu_pkg::pp_lane_t  lane_reg;
    ppu_pkg::out_item_t out_reg;
    logic               out_valid_reg;

    logic [AW-1:0]      idx;
    logic               out_free;
    logic               out_load;
    logic               found;
    logic [AW-1:0]      pick;
    logic               is_last;

    // memory and interpolator hookup
    logic               mem_we, mem_rd;
    logic [AW-1:0]      mem_waddr;
    ppu_pkg::entry_t    mem_wdata, mem_rdata;
    logic               lerp_start, lerp_done;
    logic [15:0]        l_from, l_to, l_res;

    assign idx      = cnt_reg[AW-1:0];
    assign out_free = !out_valid_reg || out_ready;
    // output register takes a new result this cycle
    assign out_load = out_free &&
                      ((state_reg == ppu_pkg::S_ADD) || (state_reg == ppu_pkg::S_EMIT));
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    function automatic logic [15:0] sat_half(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        begin
            s = {a[15], a} + {b[15], b};
            if (s[16] != s[15])
                sat_half = s[16] ? 16'h8000 : 16'h7FFF;
            else
                sat_half = s[15:0];
        end
    endfunction

    function automatic logic [31:0] sat_pair(input logic [31:0] a, input logic [31:0] b);
        sat_pair = {sat_half(a[31:16], b[31:16]), sat_half(a[15:0], b[15:0])};
    endfunction

    // lowest free slot
    always_comb
    begin
        found = 1'b0;
        pick  = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!live_reg[i])
            begin
                found = 1'b1;
                pick  = AW'(i);
            end
        end
    end

    // no live slot above the current one
    always_comb
    begin
        is_last = 1'b1;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (i > int'(idx) && live_reg[i])
                is_last = 1'b0;
        end
    end

    // lane operand select
    always_comb
    begin
        case (lane_reg)
            ppu_pkg::LN_SIZE_X: begin l_from = ent_reg.size[15:0];  l_to = ent_reg.size[47:32]; end
            ppu_pkg::LN_SIZE_Y: begin l_from = ent_reg.size[31:16]; l_to = ent_reg.size[63:48]; end
            ppu_pkg::LN_RED:    begin l_from = {8'd0, ent_reg.color[7:0]};
                                      l_to   = {8'd0, ent_reg.color[31:24]}; end
            ppu_pkg::LN_GREEN:  begin l_from = {8'd0, ent_reg.color[15:8]};
                                      l_to   = {8'd0, ent_reg.color[39:32]}; end
            ppu_pkg::LN_BLUE:   begin l_from = {8'd0, ent_reg.color[23:16]};
                                      l_to   = {8'd0, ent_reg.color[47:40]}; end
            ppu_pkg::LN_ALPHA:  begin l_from = {8'd0, ent_reg.alpha[7:0]};
                                      l_to   = {8'd0, ent_reg.alpha[15:8]}; end
            default:            begin l_from = '0; l_to = '0; end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ppu_pkg::S_IDLE:
                if (in_valid)
                    state_next = (in_data.operation == ppu_pkg::OP_TICK) ?
                                 ppu_pkg::S_FREE_RD : ppu_pkg::S_ADD;
            ppu_pkg::S_ADD:      if (out_free) state_next = ppu_pkg::S_IDLE;
            ppu_pkg::S_FREE_RD:  state_next = ppu_pkg::S_FREE_CHK;
            ppu_pkg::S_FREE_CHK:
                state_next = (cnt_reg == CW'(SLOTS - 1)) ? ppu_pkg::S_FIND : ppu_pkg::S_FREE_RD;
            ppu_pkg::S_FIND:
                if (cnt_reg == CW'(SLOTS))
                    state_next = ppu_pkg::S_IDLE;
                else if (live_reg[idx])
                    state_next = ppu_pkg::S_LOAD;
            ppu_pkg::S_LOAD:     state_next = ppu_pkg::S_VEL;
            ppu_pkg::S_VEL:      state_next = ppu_pkg::S_POS;
            ppu_pkg::S_POS:      state_next = ppu_pkg::S_LGO;
            ppu_pkg::S_LGO:      state_next = ppu_pkg::S_LWAIT;
            ppu_pkg::S_LWAIT:
                if (lerp_done)
                    state_next = (lane_reg == ppu_pkg::LN_ALPHA) ? ppu_pkg::S_WB : ppu_pkg::S_LGO;
            ppu_pkg::S_WB:       state_next = ppu_pkg::S_EMIT;
            ppu_pkg::S_EMIT:     if (out_free) state_next = ppu_pkg::S_FIND;
            default:             state_next = ppu_pkg::S_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        in_ready   = (state_reg == ppu_pkg::S_IDLE);
        lerp_start = (state_reg == ppu_pkg::S_LGO);
        mem_rd     = (state_reg == ppu_pkg::S_FREE_RD) || (state_reg == ppu_pkg::S_FIND);
        mem_we     = 1'b0;
        mem_waddr  = idx;
        mem_wdata  = ent_reg;
        case (state_reg)
            ppu_pkg::S_ADD:
            begin
                mem_we    = out_free && found;
                mem_waddr = pick;
                mem_wdata = '{frame: 16'd0, life: in_reg.life, pos: in_reg.position,
                              vel: in_reg.velocity, acc: in_reg.accel,
                              size: {in_reg.size_to, in_reg.size_from},
                              color: {in_reg.color_to, in_reg.color_from},
                              alpha: in_reg.alpha_pair};
            end
            ppu_pkg::S_WB:
            begin
                mem_we          = 1'b1;
                mem_wdata.frame = fr_reg;
                mem_wdata.vel   = vel_reg;
                mem_wdata.pos   = pos_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ppu_pkg::S_IDLE;
            live_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ppu_pkg::S_IDLE:
                    cnt_reg <= '0;
                ppu_pkg::S_ADD:
                    if (out_free && found)
                        live_reg[pick] <= 1'b1;
                ppu_pkg::S_FREE_CHK:
                begin
                    if (live_reg[idx] && mem_rdata.frame >= mem_rdata.life)
                        live_reg[idx] <= 1'b0;
                    cnt_reg <= (cnt_reg == CW'(SLOTS - 1)) ? '0 : cnt_reg + CW'(1);
                end
                ppu_pkg::S_FIND:
                    if (cnt_reg != CW'(SLOTS) && !live_reg[idx])
                        cnt_reg <= cnt_reg + CW'(1);
                ppu_pkg::S_EMIT:
                    if (out_free)
                        cnt_reg <= cnt_reg + CW'(1);
                default:
                begin
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ppu_pkg::S_IDLE:
                if (in_valid)
                    in_reg <= in_data;
            ppu_pkg::S_ADD:
                if (out_free)
                begin
                    out_reg <= '{slot: found ? ppu_pkg::SLOT_W'(pick) : ppu_pkg::SLOT_W'(0),
                                 position_out: 32'd0, size_out: 32'd0, color_out: 24'd0,
                                 alpha_out: 8'd0, accepted: found, last: 1'b1};
                end
            ppu_pkg::S_LOAD:
            begin
                ent_reg <= mem_rdata;
                fr_reg  <= mem_rdata.frame + 16'd1;
            end
            ppu_pkg::S_VEL:
                vel_reg <= sat_pair(ent_reg.vel, ent_reg.acc);
            ppu_pkg::S_POS:
            begin
                pos_reg  <= sat_pair(ent_reg.pos, vel_reg);
                lane_reg <= ppu_pkg::LN_SIZE_X;
            end
            ppu_pkg::S_LWAIT:
                if (lerp_done)
                begin
                    case (lane_reg)
                        ppu_pkg::LN_SIZE_X: size_res_reg[15:0]   <= l_res;
                        ppu_pkg::LN_SIZE_Y: size_res_reg[31:16]  <= l_res;
                        ppu_pkg::LN_RED:    color_res_reg[7:0]   <= l_res[7:0];
                        ppu_pkg::LN_GREEN:  color_res_reg[15:8]  <= l_res[7:0];
                        ppu_pkg::LN_BLUE:   color_res_reg[23:16] <= l_res[7:0];
                        ppu_pkg::LN_ALPHA:  alpha_res_reg        <= l_res[7:0];
                        default:
                        begin
                        end
                    endcase
                    lane_reg <= ppu_pkg::pp_lane_t'(lane_reg + 3'd1);
                end
            ppu_pkg::S_EMIT:
                if (out_free)
                begin
                    out_reg.slot         <= ppu_pkg::SLOT_W'(idx);
                    out_reg.position_out <= pos_reg;
                    out_reg.size_out     <= size_res_reg;
                    out_reg.color_out    <= color_res_reg;
                    out_reg.alpha_out    <= alpha_res_reg;
                    out_reg.accepted     <= 1'b0;
                    out_reg.last         <= is_last;
                end
            default:
            begin
            end
        endcase
    end

    ppu_store #(
        .SLOTS (SLOTS)
    ) u_store (
        .clk     (clk),
        .we      (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (mem_rd),
        .rd_addr (idx),
        .rd_data (mem_rdata)
    );

    ppu_lerp u_lerp (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (lerp_start),
        .from_val (l_from),
        .to_val   (l_to),
        .num      (fr_reg),
        .den      (ent_reg.life),
        .done     (lerp_done),
        .result   (l_res)
    );
endmodule

>>> sim/particle_pool_update_unit_tb.sv
// Testbench for the particle pool update unit: directed table, a full-pool test, then random traffic.
`timescale 1ns / 1ps
module particle_pool_update_unit_tb;

    localparam int NSLOT = 64;
    localparam longint CYCLE_LIMIT = 64'd12_000_000;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    ppu_pkg::in_item_t  in_data;
    logic               out_valid;
    logic               out_ready;
    ppu_pkg::out_item_t out_data;

    particle_pool_update_unit u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

    // Shadow copy of the pool
    bit               sh_live [NSLOT];
    bit   [15:0]      sh_frame[NSLOT];
    ppu_pkg::entry_t  sh_ent  [NSLOT];

    ppu_pkg::out_item_t pending_results[$];
    int          fails = 0;
    longint      cycles = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [15:0] sat_half(logic [15:0] a, logic [15:0] b);
        int s;
        s = int'($signed(a)) + int'($signed(b));
        if (s > 32767) s = 32767;
        if (s < -32768) s = -32768;
        return s[15:0];
    endfunction

    function automatic logic [31:0] sat_pair(logic [31:0] a, logic [31:0] b);
        return {sat_half(a[31:16], b[31:16]), sat_half(a[15:0], b[15:0])};
    endfunction

    // from + (to - from) * num / den, truncating toward zero
    function automatic longint blend(longint from, longint to, longint num, longint den);
        return from + ((to - from) * num) / den;
    endfunction

    // Applies one transfer to the shadow pool and queues what it should produce.
    task automatic predict_pool(ppu_pkg::in_item_t it);
        ppu_pkg::out_item_t r;
        int        first, cnt, k;
        longint    fr, lf;
        logic [15:0] tmp;
        first = -1;
        cnt = 0;
        if (it.operation == ppu_pkg::OP_ADD)
        begin
            r = '0;
            r.last = 1'b1;
            for (k = 0; k < NSLOT; k++)
                if (!sh_live[k] && first < 0) first = k;
            if (first >= 0)
            begin
                sh_live[first] = 1'b1;
                sh_frame[first] = '0;
                sh_ent[first] = '{frame: 16'd0, life: it.life, pos: it.position,
                                  vel: it.velocity, acc: it.accel,
                                  size: {it.size_to, it.size_from},
                                  color: {it.color_to, it.color_from},
                                  alpha: it.alpha_pair};
                r.slot = first[5:0];
                r.accepted = 1'b1;
            end
            pending_results.push_back(r);
            return;
        end
        // expired slots go first, then the survivors advance
        for (k = 0; k < NSLOT; k++)
            if (sh_live[k] && sh_frame[k] >= sh_ent[k].life) sh_live[k] = 1'b0;
        for (k = 0; k < NSLOT; k++)
        begin
            if (!sh_live[k]) continue;
            sh_frame[k]++;
            fr = sh_frame[k];
            lf = sh_ent[k].life;
            sh_ent[k].vel = sat_pair(sh_ent[k].vel, sh_ent[k].acc);
            sh_ent[k].pos = sat_pair(sh_ent[k].pos, sh_ent[k].vel);
            r = '0;
            r.slot = k[5:0];
            r.position_out = sh_ent[k].pos;
            tmp = 16'(blend(sh_ent[k].size[15:0], sh_ent[k].size[47:32], fr, lf));
            r.size_out[15:0] = tmp;
            tmp = 16'(blend(sh_ent[k].size[31:16], sh_ent[k].size[63:48], fr, lf));
            r.size_out[31:16] = tmp;
            for (int c = 0; c < 3; c++)
            begin
                tmp = 16'(blend(sh_ent[k].color[8*c +: 8], sh_ent[k].color[24 + 8*c +: 8],
                                fr, lf));
                r.color_out[8*c +: 8] = tmp[7:0];
            end
            tmp = 16'(blend(sh_ent[k].alpha[7:0], sh_ent[k].alpha[15:8], fr, lf));
            r.alpha_out = tmp[7:0];
            pending_results.push_back(r);
            cnt++;
        end
        if (cnt > 0) pending_results[$].last = 1'b1;
    endtask

    // Receiver: stall pattern plus field-by-field check against the oldest expectation
    int stall_mode;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("unexpected result slot=%0d", out_data.slot);
                    fails++;
                end
                else
                begin
                    ppu_pkg::out_item_t e;
                    e = pending_results.pop_front();
                    if (out_data.slot !== e.slot)
                        begin $error("slot exp %h got %h", e.slot, out_data.slot); fails++; end
                    if (out_data.position_out !== e.position_out)
                        begin $error("position_out exp %h got %h", e.position_out,
                                     out_data.position_out); fails++; end
                    if (out_data.size_out !== e.size_out)
                        begin $error("size_out exp %h got %h", e.size_out,
                                     out_data.size_out); fails++; end
                    if (out_data.color_out !== e.color_out)
                        begin $error("color_out exp %h got %h", e.color_out,
                                     out_data.color_out); fails++; end
                    if (out_data.alpha_out !== e.alpha_out)
                        begin $error("alpha_out exp %h got %h", e.alpha_out,
                                     out_data.alpha_out); fails++; end
                    if (out_data.accepted !== e.accepted)
                        begin $error("accepted exp %b got %b", e.accepted,
                                     out_data.accepted); fails++; end
                    if (out_data.last !== e.last)
                        begin $error("last exp %b got %b", e.last, out_data.last); fails++; end
                end
            end
            case (stall_mode)
                0: out_ready <= 1'b1;
                1: out_ready <= ($urandom_range(0, 3) != 0);
                default: out_ready <= (cycles[4:0] < 5'd20);
            endcase
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("particle_pool_update_unit: mismatch");
            $finish;
        end
    end

    // Directed rows; a row with check set also carries a hand-typed expectation
    typedef struct {
        ppu_pkg::in_item_t  item;
        bit                 check;
        ppu_pkg::out_item_t want;
    } row_t;

    row_t rows[$];

    function automatic ppu_pkg::in_item_t mk_add(logic [15:0] lf, logic [31:0] p,
                                        logic [31:0] v,
                                        logic [31:0] a, logic [31:0] sf, logic [31:0] st,
                                        logic [23:0] cf, logic [23:0] ct, logic [15:0] al);
        ppu_pkg::in_item_t it;
        it = '{ppu_pkg::OP_ADD, lf, p, v, a, sf, st, cf, ct, al};
        return it;
    endfunction

    function automatic ppu_pkg::in_item_t mk_tick();
        ppu_pkg::in_item_t it;
        it = '0;
        it.operation = ppu_pkg::OP_TICK;
        return it;
    endfunction

    function automatic ppu_pkg::in_item_t rand_add(int max_life);
        return mk_add(16'($urandom_range(0, max_life)), $urandom, $urandom, $urandom,
                      $urandom, $urandom, 24'($urandom), 24'($urandom), 16'($urandom));
    endfunction

    function automatic ppu_pkg::out_item_t add_ok(int s);
        ppu_pkg::out_item_t r;
        r = '0;
        r.slot = s[5:0];
        r.accepted = 1'b1;
        r.last = 1'b1;
        return r;
    endfunction

    // Sender: one transfer, with bursts and random gaps that it draws itself into gap_left
    int gap_left;
    task automatic push_item(ppu_pkg::in_item_t it);
        while (gap_left > 0)
        begin
            @(posedge clk);
            gap_left--;
        end
        predict_pool(it);
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (!(in_valid && in_ready));
        if ($urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            gap_left = $urandom_range(1, 12);
        end
    endtask

    task automatic drain_all();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    initial
    begin
        ppu_pkg::out_item_t hold;
        int n;
        gap_left = 0;
        stall_mode = 0;
        in_valid = 1'b0;
        in_data = '0;
        rst_n = 1'b0;
        foreach (sh_live[k]) sh_live[k] = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty tick after reset gives nothing; then extremes, zero life, saturation
        rows.push_back('{mk_tick(), 0, '0});
        rows.push_back('{mk_add(16'hFFFF, 32'h7FF0_8010, 32'h7FFF_8000, 32'h7FFF_8000,
                                32'h0000_FFFF, 32'hFFFF_0000, 24'h000000, 24'hFFFFFF,
                                16'hFF00), 1, add_ok(0)});
        rows.push_back('{mk_add(16'd0, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'hFFFF_FFFF,
                                32'h0, 24'hFFFFFF, 24'h0, 16'h00FF), 1, add_ok(1)});
        rows.push_back('{mk_add(16'd1, 32'h0, 32'h8000_7FFF, 32'h8000_7FFF, 32'h1234_5678,
                                32'h8765_4321, 24'h123456, 24'hABCDEF, 16'h5AA5), 1,
                         add_ok(2)});
        rows.push_back('{mk_add(16'd3, 32'h8000_7FFF, 32'hFFFF_0001, 32'h0001_FFFF,
                                32'h0100_0100, 32'h0300_0200, 24'h0A0B0C, 24'h0C0B0A,
                                16'h8001), 1, add_ok(3)});
        for (int t = 0; t < 4; t++) rows.push_back('{mk_tick(), 0, '0});
        foreach (rows[i])
        begin
            push_item(rows[i].item);
            if (rows[i].check)
            begin
                hold = pending_results[$];
                if (hold !== rows[i].want)
                begin
                    $error("table row %0d exp %h got %h", i, rows[i].want, hold);
                    fails++;
                end
            end
        end
        drain_all();

        // fill the pool, then an add on a full pool is refused
        for (n = 0; n < NSLOT; n++) push_item(rand_add(8));
        push_item(mk_add(16'd5, '1, '1, '1, '1, '1, '1, '1, '1));
        if (pending_results[$] !==
            ppu_pkg::out_item_t'({6'd0, 32'd0, 32'd0, 24'd0, 8'd0, 1'b0, 1'b1}))
        begin
            $error("pool full exp refused got %h", pending_results[$]);
            fails++;
        end
        push_item(mk_tick());
        // pause until everything has drained
        drain_all();
        // let short lives run out so the short-lived particles are freed
        for (n = 0; n < 10; n++) push_item(mk_tick());
        drain_all();

        // random traffic: mostly short lives, a few long ones, ticks sparse
        for (n = 0; n < 220; n++)
        begin
            if (n % 75 == 0) stall_mode = n / 75;
            if ($urandom_range(0, 3) == 0)
                push_item(mk_tick());
            else if ($urandom_range(0, 9) == 0)
                push_item(rand_add(65535));
            else
                push_item(rand_add(6));
            if (n == 150) drain_all();
        end
        drain_all();

        if (fails == 0)
            $display("particle_pool_update_unit: match");
        else
            $display("particle_pool_update_unit: mismatch");
        $finish;
    end
endmodule

>>> filelist.f
rtl/ppu_pkg.sv
rtl/ppu_store.sv
rtl/ppu_lerp.sv
rtl/particle_pool_update_unit.sv
sim/particle_pool_update_unit_tb.sv
